/* rtl/ctr_pkg.sv */
// shared constants, widths and the color rom for the color temperature converter
// no dependencies
package ctr_pkg;

    localparam int FRAC_BITS = 12;
    localparam int KMIN      = 2000;
    localparam int KMAX      = 6500;
    localparam int KSPAN     = KMAX - KMIN;
    localparam int LUT_SIZE  = 48;

    localparam int K_W   = 14;                // input width
    localparam int T_W   = 13;                // clamped offset, 0..KSPAN
    localparam int P_W   = 18;                // offset times (LUT_SIZE - 1)
    localparam int IDX_W = 6;                 // rom index
    localparam int REM_W = 13;                // remainder below KSPAN
    localparam int X_W   = REM_W + FRAC_BITS; // remainder scaled by the fraction
    localparam int ONE_W = FRAC_BITS + 1;     // holds 2^FRAC_BITS

    // floor reciprocals of KSPAN; quotient estimate is low by at most one
    localparam int M1_W = P_W - 12;
    localparam int M2_W = X_W - 12;
    localparam longint unsigned M1 = (64'd1 << P_W) / KSPAN;
    localparam longint unsigned M2 = (64'd1 << X_W) / KSPAN;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(LUT_SIZE - 1);

    typedef struct packed {
        logic prod;
        logic sum;
    } t_blend_en;

    function automatic logic [23:0] lut_rgb(input logic [IDX_W-1:0] idx);
        logic [23:0] v;
        case (idx)
            6'd0:  v = {8'd255, 8'd138, 8'd18};
            6'd1:  v = {8'd255, 8'd142, 8'd33};
            6'd2:  v = {8'd255, 8'd147, 8'd44};
            6'd3:  v = {8'd255, 8'd152, 8'd54};
            6'd4:  v = {8'd255, 8'd157, 8'd63};
            6'd5:  v = {8'd255, 8'd161, 8'd72};
            6'd6:  v = {8'd255, 8'd165, 8'd79};
            6'd7:  v = {8'd255, 8'd169, 8'd87};
            6'd8:  v = {8'd255, 8'd173, 8'd94};
            6'd9:  v = {8'd255, 8'd177, 8'd101};
            6'd10: v = {8'd255, 8'd180, 8'd107};
            6'd11: v = {8'd255, 8'd184, 8'd114};
            6'd12: v = {8'd255, 8'd187, 8'd120};
            6'd13: v = {8'd255, 8'd190, 8'd126};
            6'd14: v = {8'd255, 8'd193, 8'd132};
            6'd15: v = {8'd255, 8'd196, 8'd137};
            6'd16: v = {8'd255, 8'd199, 8'd143};
            6'd17: v = {8'd255, 8'd201, 8'd148};
            6'd18: v = {8'd255, 8'd204, 8'd153};
            6'd19: v = {8'd255, 8'd206, 8'd159};
            6'd20: v = {8'd255, 8'd209, 8'd163};
            6'd21: v = {8'd255, 8'd211, 8'd168};
            6'd22: v = {8'd255, 8'd213, 8'd173};
            6'd23: v = {8'd255, 8'd215, 8'd177};
            6'd24: v = {8'd255, 8'd217, 8'd182};
            6'd25: v = {8'd255, 8'd219, 8'd186};
            6'd26: v = {8'd255, 8'd221, 8'd190};
            6'd27: v = {8'd255, 8'd223, 8'd194};
            6'd28: v = {8'd255, 8'd225, 8'd198};
            6'd29: v = {8'd255, 8'd227, 8'd202};
            6'd30: v = {8'd255, 8'd228, 8'd206};
            6'd31: v = {8'd255, 8'd230, 8'd210};
            6'd32: v = {8'd255, 8'd232, 8'd213};
            6'd33: v = {8'd255, 8'd233, 8'd217};
            6'd34: v = {8'd255, 8'd235, 8'd220};
            6'd35: v = {8'd255, 8'd236, 8'd224};
            6'd36: v = {8'd255, 8'd238, 8'd227};
            6'd37: v = {8'd255, 8'd239, 8'd230};
            6'd38: v = {8'd255, 8'd240, 8'd233};
            6'd39: v = {8'd255, 8'd242, 8'd236};
            6'd40: v = {8'd255, 8'd243, 8'd239};
            6'd41: v = {8'd255, 8'd244, 8'd242};
            6'd42: v = {8'd255, 8'd245, 8'd245};
            6'd43: v = {8'd255, 8'd246, 8'd247};
            6'd44: v = {8'd255, 8'd248, 8'd251};
            6'd45: v = {8'd255, 8'd249, 8'd253};
            6'd46: v = {8'd254, 8'd252, 8'd255};
            6'd47: v = {8'd255, 8'd255, 8'd255};
            default: v = {8'd255, 8'd255, 8'd255};
        endcase
        return v;
    endfunction

endpackage

/* rtl/ctr_blend.sv */
// two-stage linear blend of one color channel between neighboring rom entries
// depends on ctr_pkg
module ctr_blend import ctr_pkg::*; (
    input  logic                 i_clk,
    input  t_blend_en            i_en,
    input  logic [7:0]           i_a,
    input  logic [7:0]           i_b,
    input  logic [FRAC_BITS-1:0] i_f,
    output logic [7:0]           o_ch
);

    localparam int PR_W = 8 + ONE_W;

    logic [PR_W-1:0] r_pa, r_pb, n_pa, n_pb;
    logic [PR_W-1:0] sum;
    logic [7:0]      r_ch;
    logic [ONE_W-1:0] one_m_f;

    always_comb begin
        one_m_f = (ONE_W'(1) << FRAC_BITS) - {1'b0, i_f};
        n_pa    = PR_W'(i_a) * PR_W'(one_m_f);
        n_pb    = PR_W'(i_b) * PR_W'({1'b0, i_f});
    end

    // the weighted sum never exceeds 255 scaled, so the top bit stays clear
    assign sum = r_pa + r_pb;

    always_ff @(posedge i_clk) begin
        if (i_en.prod) begin
            r_pa <= n_pa;
            r_pb <= n_pb;
        end
        if (i_en.sum) begin
            r_ch <= sum[FRAC_BITS+7:FRAC_BITS];
        end
    end

    assign o_ch = r_ch;

endmodule

/* rtl/color_temperature_to_rgb_top.sv */
// top level of the color temperature to rgb converter
// depends on ctr_pkg and ctr_blend
//
// usage:
//   input request: i_valid / o_ready with i_kelvin (14 bits). values below
//   2000 are taken as 2000 and values above 6500 as 6500.
//   output request: o_valid / i_ready with o_red, o_green, o_blue.
//   path: an accepted request passes through the stage registers listed below
//   in order and reaches o_valid from the last one.
//   throughput: one conversion per cycle unless the output stalls; every
//   stage is one register after small arithmetic or a rom read; the stages are:
//   clamp, scale by 47, quotient estimate, quotient fix, fraction estimate
//   with rom read, fraction fix, channel products, channel sum.
//   stalls: each stage moves when it is empty or the next one moves, so a
//   stalled receiver holds the result in the output register while the
//   bubbles further back still fill; o_ready drops only when all eight
//   stages hold a request.
//   reset: clears all valid bits; the data registers are not reset.
module color_temperature_to_rgb_top import ctr_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [K_W-1:0] i_kelvin,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_red,
    output logic [7:0]     o_green,
    output logic [7:0]     o_blue
);

    localparam int NST = 8;

    logic [NST:1]   r_v;
    logic [NST+1:1] rdy;

    always_comb begin
        rdy[NST+1] = i_ready;
        for (int k = NST; k >= 1; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (rdy[1]) begin
                r_v[1] <= i_valid;
            end
            for (int k = 2; k <= NST; k++) begin
                if (rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // stage 1: clamp and offset
    logic [T_W-1:0] r_t1, n_t1;

    always_comb begin
        if (i_kelvin < K_W'(KMIN)) begin
            n_t1 = '0;
        end else if (i_kelvin > K_W'(KMAX)) begin
            n_t1 = T_W'(KSPAN);
        end else begin
            n_t1 = T_W'(i_kelvin - K_W'(KMIN));
        end
    end

    // stage 2: position on the rom scale
    logic [P_W-1:0] r_p2;

    // stage 3: quotient estimate
    logic [P_W+M1_W-1:0] q_prod;
    logic [IDX_W-1:0]    r_q3;
    logic [P_W-1:0]      r_p3;

    assign q_prod = (P_W+M1_W)'(r_p2) * (P_W+M1_W)'(M1);

    // stage 4: quotient fix
    logic [P_W-1:0]   rem0;
    logic [IDX_W-1:0] n_idx4, r_idx4;
    logic [REM_W-1:0] n_rem4, r_rem4;

    always_comb begin
        rem0 = r_p3 - P_W'(P_W'(r_q3) * P_W'(KSPAN));
        if (rem0 >= P_W'(KSPAN)) begin
            n_idx4 = r_q3 + IDX_W'(1);
            n_rem4 = REM_W'(rem0 - P_W'(KSPAN));
        end else begin
            n_idx4 = r_q3;
            n_rem4 = REM_W'(rem0);
        end
    end

    // stage 5: fraction estimate and rom read
    logic [X_W-1:0]       x5;
    logic [X_W+M2_W-1:0]  f_prod;
    logic [FRAC_BITS-1:0] r_f5;
    logic [REM_W-1:0]     r_rem5;
    logic [IDX_W-1:0]     nxt;
    logic [23:0]          r_a5, r_b5;

    always_comb begin
        x5     = {r_rem4, {FRAC_BITS{1'b0}}};
        f_prod = (X_W+M2_W)'(x5) * (X_W+M2_W)'(M2);
        // top entry has no right neighbor; its fraction is zero anyway
        nxt    = (r_idx4 == IDX_LAST) ? r_idx4 : r_idx4 + IDX_W'(1);
    end

    // stage 6: fraction fix
    logic [X_W-1:0]       x6, r6;
    logic [FRAC_BITS-1:0] n_f6, r_f6;
    logic [23:0]          r_a6, r_b6;

    always_comb begin
        x6 = {r_rem5, {FRAC_BITS{1'b0}}};
        r6 = x6 - X_W'(X_W'(r_f5) * X_W'(KSPAN));
        n_f6 = (r6 >= X_W'(KSPAN)) ? r_f5 + FRAC_BITS'(1) : r_f5;
    end

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r_t1 <= n_t1;
        end
        if (rdy[2]) begin
            r_p2 <= P_W'(r_t1) * P_W'(LUT_SIZE - 1);
        end
        if (rdy[3]) begin
            r_q3 <= IDX_W'(q_prod >> P_W);
            r_p3 <= r_p2;
        end
        if (rdy[4]) begin
            r_idx4 <= n_idx4;
            r_rem4 <= n_rem4;
        end
        if (rdy[5]) begin
            r_f5   <= FRAC_BITS'(f_prod >> X_W);
            r_rem5 <= r_rem4;
            r_a5   <= lut_rgb(r_idx4);
            r_b5   <= lut_rgb(nxt);
        end
        if (rdy[6]) begin
            r_f6 <= n_f6;
            r_a6 <= r_a5;
            r_b6 <= r_b5;
        end
    end

    // stages 7 and 8: per channel blend
    t_blend_en blend_en;

    assign blend_en.prod = rdy[7];
    assign blend_en.sum  = rdy[8];

    ctr_blend u_red (
        .i_clk (i_clk),
        .i_en  (blend_en),
        .i_a   (r_a6[23:16]),
        .i_b   (r_b6[23:16]),
        .i_f   (r_f6),
        .o_ch  (o_red)
    );

    ctr_blend u_green (
        .i_clk (i_clk),
        .i_en  (blend_en),
        .i_a   (r_a6[15:8]),
        .i_b   (r_b6[15:8]),
        .i_f   (r_f6),
        .o_ch  (o_green)
    );

    ctr_blend u_blue (
        .i_clk (i_clk),
        .i_en  (blend_en),
        .i_a   (r_a6[7:0]),
        .i_b   (r_b6[7:0]),
        .i_f   (r_f6),
        .o_ch  (o_blue)
    );

    assign o_ready = rdy[1];
    assign o_valid = r_v[NST];

endmodule
